/* hdl/lncg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lncg_pkg
// Shared types and constants of the last-note-priority CV/gate converter.
// ----------------------------------------------------------------------------
package lncg_pkg;

   localparam int LNCG_TABLE_DEPTH = 48;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 33;

   localparam logic [2:0] OP_NOTE_ON    = 3'd0;
   localparam logic [2:0] OP_NOTE_OFF   = 3'd1;
   localparam logic [2:0] OP_PRESSURE   = 3'd2;
   localparam logic [2:0] OP_DISABLE    = 3'd3;
   localparam logic [2:0] OP_POWER_LOST = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLED         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_NOTE        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_SLOPE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_OFFSET    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSURE_SLOPE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSURE_OFFSET = 3'd5;

   localparam logic signed [31:0] PITCH_SLOPE_RST    = 32'sd35790848;
   localparam logic signed [31:0] PRESSURE_SLOPE_RST = 32'sd33818123;

   typedef enum logic [1:0] {
      SCAN_FREE,
      SCAN_OFF,
      SCAN_NEWEST
   } lncg_scan_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_GO,
      ST_SCAN_WAIT,
      ST_CONV_GO,
      ST_CONV_WAIT,
      ST_OUT
   } lncg_state_type;

   typedef struct packed {
      logic               start;
      lncg_scan_mode_type mode;
      logic [6:0]         note;
      logic [31:0]        claim;
      logic               clear_all;
   } lncg_tbl_ctl_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic       found;
      logic [6:0] best_note;
   } lncg_tbl_st_type;

   typedef struct packed {
      logic                pitch_write;
      logic [15:0]         pitch_code;
      logic                pressure_write;
      logic [15:0]         pressure_code;
      logic                gate;
      logic                dropped;
   } lncg_result_type;

endpackage : lncg_pkg
`default_nettype wire

/* hdl/lncg_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lncg_ifs
// Valid/ready channel interfaces: note events, DAC results, register writes.
// ----------------------------------------------------------------------------
interface lncg_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [6:0] note;
   logic [6:0] pressure;
   logic       power_ok;

   modport source (output valid, output op, output note, output pressure,
                   output power_ok, input ready);
   modport sink   (input valid, input op, input note, input pressure,
                   input power_ok, output ready);
endinterface : lncg_req_if

interface lncg_rsp_if;
   logic        valid;
   logic        ready;
   logic        pitch_write;
   logic [15:0] pitch_code;
   logic        pressure_write;
   logic [15:0] pressure_code;
   logic        gate;
   logic        dropped;

   modport source (output valid, output pitch_write, output pitch_code,
                   output pressure_write, output pressure_code, output gate,
                   output dropped, input ready);
   modport sink   (input valid, input pitch_write, input pitch_code,
                   input pressure_write, input pressure_code, input gate,
                   input dropped, output ready);
endinterface : lncg_rsp_if

interface lncg_csr_if import lncg_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface : lncg_csr_if
`default_nettype wire

/* hdl/lncg_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lncg_table
// Held-note slot table: active bits in flops, note/claim in a memory with
// one read and one write port, scanned one slot per cycle for free slot,
// note-off match and newest claim.
// ----------------------------------------------------------------------------
module lncg_table
   import lncg_pkg::*;
#(
   parameter int TABLE_DEPTH = LNCG_TABLE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lncg_tbl_ctl_type ctl,
   output lncg_tbl_st_type       st
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

   logic [38:0]            mem [TABLE_DEPTH];
   logic [38:0]            rd_ff;
   logic [TABLE_DEPTH-1:0] active_ff;

   logic                   run_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic                   ev_vld_ff;
   logic [IDX_W-1:0]       ev_idx_ff;
   logic                   done_ff;

   lncg_scan_mode_type     mode_ff;
   logic [6:0]             note_ff;
   logic [31:0]            claim_ff;

   logic                   found_ff;
   logic                   matched_ff;
   logic [31:0]            best_claim_ff;
   logic [6:0]             best_note_ff;

   logic                   ev_act;
   logic [6:0]             rd_note;
   logic [31:0]            rd_claim;
   logic                   take_free;
   logic                   take_match;
   logic                   take_best;

   assign ev_act   = active_ff[ev_idx_ff];
   assign rd_note  = rd_ff[38:32];
   assign rd_claim = rd_ff[31:0];

   always_comb begin
      take_free  = 1'b0;
      take_match = 1'b0;
      take_best  = 1'b0;
      if (ev_vld_ff) begin
         unique case (mode_ff)
            SCAN_FREE: begin
               take_free = !ev_act && !found_ff;
            end
            SCAN_OFF: begin
               take_match = ev_act && !matched_ff && (rd_note == note_ff);
               take_best  = ev_act && !take_match &&
                            (!found_ff || (rd_claim > best_claim_ff));
            end
            default: begin
               take_best = ev_act && (!found_ff || (rd_claim > best_claim_ff));
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         ev_vld_ff  <= 1'b0;
         done_ff    <= 1'b0;
         found_ff   <= 1'b0;
         matched_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         done_ff   <= ev_vld_ff && (ev_idx_ff == LAST);
         ev_vld_ff <= run_ff;
         if (ctl.start) begin
            run_ff     <= 1'b1;
            idx_ff     <= '0;
            found_ff   <= 1'b0;
            matched_ff <= 1'b0;
         end else begin
            if (run_ff) begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == LAST) begin
                  run_ff <= 1'b0;
               end
            end
            if (take_free || take_best) begin
               found_ff <= 1'b1;
            end
            if (take_match) begin
               matched_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff <= idx_ff;
      if (ctl.start) begin
         mode_ff  <= ctl.mode;
         note_ff  <= ctl.note;
         claim_ff <= ctl.claim;
      end
      if (take_best) begin
         best_claim_ff <= rd_claim;
         best_note_ff  <= rd_note;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear_all) begin
         active_ff <= '0;
      end else if (take_free) begin
         active_ff[ev_idx_ff] <= 1'b1;
      end else if (take_match) begin
         active_ff[ev_idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_free) begin
         mem[ev_idx_ff] <= {note_ff, claim_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (run_ff) begin
         rd_ff <= mem[idx_ff];
      end
   end

   assign st.busy      = run_ff || ev_vld_ff;
   assign st.done      = done_ff;
   assign st.found     = found_ff;
   assign st.best_note = best_note_ff;

endmodule : lncg_table
`default_nettype wire

/* hdl/lncg_conv.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lncg_conv
// Shared DAC code unit: Q16.16 multiply, offset add, round half up and
// clamp to 0..65535. Three registered steps.
// ----------------------------------------------------------------------------
module lncg_conv
   import lncg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [7:0]  delta,
   input  wire logic signed [31:0] slope,
   input  wire logic signed [32:0] offset,
   output logic                    done,
   output logic [15:0]             code
);

   logic [2:0]         vld_ff;
   logic signed [39:0] prod_ff;
   logic signed [32:0] off_ff;
   logic signed [40:0] sum_ff;
   logic signed [40:0] sum_in;
   logic [40:0]        rnd;
   logic [15:0]        code_ff;
   logic [15:0]        code_in;

   assign sum_in = $signed({prod_ff[39], prod_ff}) + $signed({{8{off_ff[32]}}, off_ff});
   assign rnd    = {1'b0, sum_ff[39:0]} + 41'd32768;

   always_comb begin
      if (sum_ff[40]) begin
         code_in = 16'd0;
      end else if (|rnd[40:32]) begin
         code_in = 16'hFFFF;
      end else begin
         code_in = rnd[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], start};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= delta * slope;
         off_ff  <= offset;
      end
      sum_ff  <= sum_in;
      code_ff <= code_in;
   end

   assign done = vld_ff[2];
   assign code = code_ff;

endmodule : lncg_conv
`default_nettype wire

/* hdl/last_note_priority_cv_gate.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// last_note_priority_cv_gate
// Last-note-priority note-to-CV/gate converter with Q16.16 DAC scaling.
//
//   channel   dir  handshake            beat
//   req_chan  in   valid/ready          op, note, pressure, power_ok
//   rsp_chan  out  valid/ready          DAC writes and codes, gate, dropped
//   csr_chan  in   valid/ready (ready=1) register index, data
//
// Note on, note off and pressure scan the slot table one slot per cycle
// through its memory read port, then start the three-step conversion
// unit when a DAC code is computed. Other ops, and any op while disabled
// or without power, go straight to the output register.
// Reset is synchronous; active bits clear at once, no clearing pass.
// A new beat is accepted while the previous result waits in the output
// register; the sequencer holds only if that register is still full.
// ----------------------------------------------------------------------------
module last_note_priority_cv_gate
   import lncg_pkg::*;
#(
   parameter int TABLE_DEPTH = LNCG_TABLE_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lncg_req_if.sink   req_chan,
   lncg_rsp_if.source rsp_chan,
   lncg_csr_if.sink   csr_chan
);

   lncg_state_type     state_ff;
   lncg_state_type     state_in;

   logic               enabled_ff;
   logic [6:0]         ref_note_ff;
   logic signed [31:0] pitch_slope_ff;
   logic signed [32:0] pitch_offset_ff;
   logic signed [31:0] pressure_slope_ff;
   logic signed [32:0] pressure_offset_ff;

   logic [2:0]         op_ff;
   logic [6:0]         note_ff;
   logic [6:0]         pres_ff;
   logic               pow_ff;

   logic               gate_ff;
   logic [31:0]        next_claim_ff;
   lncg_scan_mode_type mode_ff;
   logic               sel_pres_ff;
   logic signed [7:0]  delta_ff;
   lncg_result_type    res_ff;

   logic               rsp_valid_ff;
   lncg_result_type    rsp_res_ff;

   lncg_tbl_ctl_type   tbl_ctl;
   lncg_tbl_st_type    tbl_st;
   logic               conv_start;
   logic               conv_done;
   logic [15:0]        conv_code;

   logic               item_active;
   logic               safe_off;
   logic               out_load;
   logic               accept;

   assign item_active = enabled_ff && pow_ff;
   assign safe_off    = (op_ff == OP_DISABLE) || ((op_ff == OP_POWER_LOST) && gate_ff);
   assign out_load    = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept      = req_chan.valid && req_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (item_active && ((op_ff == OP_NOTE_ON) || (op_ff == OP_NOTE_OFF) ||
                                (op_ff == OP_PRESSURE))) begin
               state_in = ST_SCAN_GO;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SCAN_GO: begin
            state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: begin
            if (tbl_st.done) begin
               unique case (mode_ff)
                  SCAN_FREE: state_in = ST_CONV_GO;
                  SCAN_OFF:  state_in = tbl_st.found ? ST_CONV_GO : ST_OUT;
                  default: begin
                     state_in = (tbl_st.found && (tbl_st.best_note == note_ff)) ?
                                ST_CONV_GO : ST_OUT;
                  end
               endcase
            end
         end
         ST_CONV_GO: begin
            state_in = ST_CONV_WAIT;
         end
         ST_CONV_WAIT: begin
            if (conv_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready    = 1'b0;
      tbl_ctl.start     = 1'b0;
      tbl_ctl.clear_all = 1'b0;
      tbl_ctl.mode      = mode_ff;
      tbl_ctl.note      = note_ff;
      tbl_ctl.claim     = next_claim_ff;
      conv_start        = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_chan.ready    = 1'b1;
         ST_DECODE:  tbl_ctl.clear_all = safe_off;
         ST_SCAN_GO: tbl_ctl.start     = 1'b1;
         ST_CONV_GO: conv_start        = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff         <= 1'b0;
         ref_note_ff        <= 7'd0;
         pitch_slope_ff     <= PITCH_SLOPE_RST;
         pitch_offset_ff    <= '0;
         pressure_slope_ff  <= PRESSURE_SLOPE_RST;
         pressure_offset_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_ENABLED:         enabled_ff         <= csr_chan.data[0];
            CSR_REF_NOTE:        ref_note_ff        <= csr_chan.data[6:0];
            CSR_PITCH_SLOPE:     pitch_slope_ff     <= $signed(csr_chan.data[31:0]);
            CSR_PITCH_OFFSET:    pitch_offset_ff    <= $signed(csr_chan.data[32:0]);
            CSR_PRESSURE_SLOPE:  pressure_slope_ff  <= $signed(csr_chan.data[31:0]);
            CSR_PRESSURE_OFFSET: pressure_offset_ff <= $signed(csr_chan.data[32:0]);
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff       <= 1'b0;
         next_claim_ff <= 32'd1;
      end else begin
         if ((state_ff == ST_DECODE) && safe_off) begin
            gate_ff <= 1'b0;
         end
         if ((state_ff == ST_SCAN_WAIT) && tbl_st.done) begin
            if (mode_ff == SCAN_FREE) begin
               gate_ff <= 1'b1;
               if (tbl_st.found) begin
                  next_claim_ff <= next_claim_ff + 32'd1;
               end
            end else if ((mode_ff == SCAN_OFF) && !tbl_st.found) begin
               gate_ff <= 1'b0;
            end
         end
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_chan.op;
         note_ff <= req_chan.note;
         pres_ff <= req_chan.pressure;
         pow_ff  <= req_chan.power_ok;
      end
      unique case (state_ff)
         ST_DECODE: begin
            res_ff <= '{pitch_write:    safe_off,
                        pitch_code:     16'd0,
                        pressure_write: safe_off,
                        pressure_code:  16'd0,
                        gate:           1'b0,
                        dropped:        1'b0};
            unique case (op_ff)
               OP_NOTE_ON:  mode_ff <= SCAN_FREE;
               OP_NOTE_OFF: mode_ff <= SCAN_OFF;
               default:     mode_ff <= SCAN_NEWEST;
            endcase
         end
         ST_SCAN_WAIT: begin
            if (tbl_st.done) begin
               unique case (mode_ff)
                  SCAN_FREE: begin
                     res_ff.dropped     <= !tbl_st.found;
                     res_ff.pitch_write <= 1'b1;
                     sel_pres_ff        <= 1'b0;
                     delta_ff           <= $signed({1'b0, note_ff} - {1'b0, ref_note_ff});
                  end
                  SCAN_OFF: begin
                     res_ff.pitch_write <= tbl_st.found;
                     sel_pres_ff        <= 1'b0;
                     delta_ff           <= $signed({1'b0, tbl_st.best_note} -
                                                   {1'b0, ref_note_ff});
                  end
                  default: begin
                     res_ff.pressure_write <= tbl_st.found && (tbl_st.best_note == note_ff);
                     sel_pres_ff           <= 1'b1;
                     delta_ff              <= $signed({1'b0, pres_ff});
                  end
               endcase
            end
         end
         ST_CONV_WAIT: begin
            if (conv_done) begin
               if (sel_pres_ff) begin
                  res_ff.pressure_code <= conv_code;
               end else begin
                  res_ff.pitch_code <= conv_code;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_res_ff <= '{pitch_write:    res_ff.pitch_write,
                         pitch_code:     res_ff.pitch_code,
                         pressure_write: res_ff.pressure_write,
                         pressure_code:  res_ff.pressure_code,
                         gate:           gate_ff,
                         dropped:        res_ff.dropped};
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.pitch_write    = rsp_res_ff.pitch_write;
   assign rsp_chan.pitch_code     = rsp_res_ff.pitch_code;
   assign rsp_chan.pressure_write = rsp_res_ff.pressure_write;
   assign rsp_chan.pressure_code  = rsp_res_ff.pressure_code;
   assign rsp_chan.gate           = rsp_res_ff.gate;
   assign rsp_chan.dropped        = rsp_res_ff.dropped;

   lncg_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .ctl   (tbl_ctl),
      .st    (tbl_st)
   );

   lncg_conv u_conv (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .delta  (delta_ff),
      .slope  (sel_pres_ff ? pressure_slope_ff : pitch_slope_ff),
      .offset (sel_pres_ff ? pressure_offset_ff : pitch_offset_ff),
      .done   (conv_done),
      .code   (conv_code)
   );

`ifndef ASSERT_OFF
   a_idle_no_scan: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !tbl_st.busy)
      else $error("input ready while slot scan is running");

   a_scan_done_state: assert property (@(posedge clock) disable iff (reset)
      tbl_st.done |-> (state_ff == ST_SCAN_WAIT))
      else $error("scan finished outside its wait state");

   a_conv_done_state: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> (state_ff == ST_CONV_WAIT))
      else $error("conversion finished outside its wait state");

   a_disable_gate_low: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && (op_ff == OP_DISABLE)) |-> !gate_ff)
      else $error("gate high after disable");
`endif

endmodule : last_note_priority_cv_gate
`default_nettype wire
